>>> hdl/assert_macros.svh
// Assertion macros for the checker file of the shelf packer.
// Each macro takes a label, a clock, an active-low reset and a property.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// The expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

>>> hdl/sap_pkg.sv
// Package of the shelf atlas packer: sizes, codes, register map and the
// structs passed between controller, datapath and register block. No dependencies.
`default_nettype none

package sap_pkg;

	localparam int MAX_PAGES = 8;
	localparam int PAGE_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int CNT_W = $clog2(MAX_PAGES + 1);
	localparam int DIM_W = 12;
	localparam int SIZE_W = 13;
	localparam int GAP_W = 8;
	localparam int IDX_OUT_W = 3;
	localparam int STATUS_W = 2;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int REG_IDX_W = 2;

	localparam logic [SIZE_W-1:0] DIM_CAP = SIZE_W'(4096);
	localparam logic [SIZE_W-1:0] RST_ATLAS_WIDTH = SIZE_W'(1024);
	localparam logic [SIZE_W-1:0] RST_ATLAS_HEIGHT = SIZE_W'(1024);
	localparam logic [GAP_W-1:0] RST_SHELF_GAP = '0;

	localparam logic [REG_IDX_W-1:0] REG_ATLAS_WIDTH = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ATLAS_HEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SHELF_GAP = 2'd2;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_PLACED = 2'd0,
		ST_TOO_LARGE = 2'd1,
		ST_NO_PAGE = 2'd2,
		ST_CLEARED = 2'd3
	} status_t;

	typedef struct packed {
		logic [SIZE_W-1:0] atlas_width;
		logic [SIZE_W-1:0] atlas_height;
		logic [GAP_W-1:0] shelf_gap;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic advance;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic is_clear;
		logic fits;
		logic last;
	} stat_t;

endpackage

`default_nettype wire

>>> hdl/sap_if.sv
// Word channels of the shelf packer: request words in, result words out.
// Depends on sap_pkg for the field widths and the status type.
`default_nettype none

interface sap_req_if;
	import sap_pkg::*;
	logic valid;
	logic ready;
	logic action;
	logic [DIM_W-1:0] quad_width;
	logic [DIM_W-1:0] quad_height;
	modport source (output valid, action, quad_width, quad_height, input ready);
	modport sink (input valid, action, quad_width, quad_height, output ready);
endinterface

interface sap_rsp_if;
	import sap_pkg::*;
	logic valid;
	logic ready;
	status_t status;
	logic [IDX_OUT_W-1:0] page_index;
	logic [DIM_W-1:0] pos_x;
	logic [DIM_W-1:0] pos_y;
	logic opened_page;
	modport source (output valid, status, page_index, pos_x, pos_y, opened_page,
		input ready);
	modport sink (input valid, status, page_index, pos_x, pos_y, opened_page,
		output ready);
endinterface

`default_nettype wire

>>> hdl/sap_regs.sv
// APB-style register block holding page width, page height and shelf gap.
// Depends on sap_pkg for the register map and the configuration struct.
`default_nettype none

module sap_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [sap_pkg::ADDR_W-1:0] paddr,
	input wire logic [sap_pkg::DATA_W-1:0] pwdata,
	output logic [sap_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output sap_pkg::cfg_t cfg
);
	import sap_pkg::*;

	cfg_t cfg_q;
	logic wr_en;
	logic [REG_IDX_W-1:0] reg_idx;
	logic addr_hit;

	assign pready = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign addr_hit = (paddr[1:0] == 2'b00);
	assign wr_en = psel && penable && pwrite && pready && addr_hit;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.atlas_width <= RST_ATLAS_WIDTH;
			cfg_q.atlas_height <= RST_ATLAS_HEIGHT;
			cfg_q.shelf_gap <= RST_SHELF_GAP;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ATLAS_WIDTH: cfg_q.atlas_width <= pwdata[SIZE_W-1:0];
				REG_ATLAS_HEIGHT: cfg_q.atlas_height <= pwdata[SIZE_W-1:0];
				REG_SHELF_GAP: cfg_q.shelf_gap <= pwdata[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (addr_hit) begin
			unique case (reg_idx)
				REG_ATLAS_WIDTH: prdata = DATA_W'(cfg_q.atlas_width);
				REG_ATLAS_HEIGHT: prdata = DATA_W'(cfg_q.atlas_height);
				REG_SHELF_GAP: prdata = DATA_W'(cfg_q.shelf_gap);
				default: prdata = '0;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hdl/sap_ctrl.sv
// Controller of the shelf packer: takes a word, walks the pages one per cycle
// and hands the finished result to the output register once it is free. Depends on sap_pkg.
`default_nettype none

module sap_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input wire logic rsp_ready,
	input wire sap_pkg::stat_t stat,
	output sap_pkg::cmd_t cmd
);
	import sap_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_WALK = 2'b10
	} state_t;

	state_t state_q;
	logic rsp_valid_q;
	logic out_free;
	logic done_now;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign out_free = !rsp_valid_q || rsp_ready;
	assign done_now = stat.is_clear || stat.fits || stat.last;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.load = req_valid;
			S_WALK: begin
				cmd.finish = done_now && out_free;
				cmd.advance = !done_now;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (req_valid) begin
					state_q <= S_WALK;
				end
				S_WALK: if (cmd.finish) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hdl/sap_dp.sv
// Datapath of the shelf packer: page records, the trial placement on the
// current page and the result register. Depends on sap_pkg.
`default_nettype none

module sap_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire sap_pkg::cfg_t cfg,
	input wire sap_pkg::cmd_t cmd,
	input wire logic in_action,
	input wire logic [sap_pkg::DIM_W-1:0] in_quad_width,
	input wire logic [sap_pkg::DIM_W-1:0] in_quad_height,
	output sap_pkg::stat_t stat,
	output sap_pkg::status_t out_status,
	output logic [sap_pkg::IDX_OUT_W-1:0] out_page_index,
	output logic [sap_pkg::DIM_W-1:0] out_pos_x,
	output logic [sap_pkg::DIM_W-1:0] out_pos_y,
	output logic out_opened_page
);
	import sap_pkg::*;

	logic action_q;
	logic [DIM_W-1:0] qw_q;
	logic [DIM_W-1:0] qh_q;
	logic [PAGE_W-1:0] page_q;
	logic [CNT_W-1:0] used_q;
	logic [DIM_W-1:0] cur_x_q [MAX_PAGES];
	logic [DIM_W-1:0] cur_y_q [MAX_PAGES];
	logic [DIM_W-1:0] shelf_q [MAX_PAGES];

	logic [SIZE_W-1:0] w_cap;
	logic [SIZE_W-1:0] h_cap;
	logic [DIM_W-1:0] x_rd;
	logic [DIM_W-1:0] y_rd;
	logic [DIM_W-1:0] sh_rd;
	logic [SIZE_W-1:0] right_edge;
	logic wrap;
	logic [DIM_W+1:0] y_next_shelf;
	logic [DIM_W+1:0] y_try;
	logic [DIM_W-1:0] x_try;
	logic [DIM_W-1:0] sh_try;
	logic [DIM_W+2:0] bottom;
	logic fits;
	logic too_large;
	logic full;
	logic [PAGE_W-1:0] new_page;

	status_t res_status;
	logic [IDX_OUT_W-1:0] res_page_index;
	logic [DIM_W-1:0] res_pos_x;
	logic [DIM_W-1:0] res_pos_y;
	logic res_opened_page;

	assign w_cap = (cfg.atlas_width > DIM_CAP) ? DIM_CAP : cfg.atlas_width;
	assign h_cap = (cfg.atlas_height > DIM_CAP) ? DIM_CAP : cfg.atlas_height;

	assign x_rd = cur_x_q[page_q];
	assign y_rd = cur_y_q[page_q];
	assign sh_rd = shelf_q[page_q];

	assign right_edge = {1'b0, x_rd} + {1'b0, qw_q};
	assign wrap = right_edge >= w_cap;
	assign y_next_shelf = {2'b00, y_rd} + {2'b00, sh_rd} + (DIM_W + 2)'(cfg.shelf_gap);
	assign y_try = wrap ? y_next_shelf : {2'b00, y_rd};
	assign x_try = wrap ? '0 : x_rd;
	assign sh_try = wrap ? '0 : sh_rd;
	assign bottom = {1'b0, y_try} + (DIM_W + 3)'(qh_q);
	assign fits = bottom < (DIM_W + 3)'(h_cap);

	assign too_large = ({1'b0, qw_q} >= w_cap) || ({1'b0, qh_q} >= h_cap);
	assign full = used_q >= CNT_W'(MAX_PAGES);
	assign new_page = used_q[PAGE_W-1:0];

	assign stat.is_clear = (action_q == ACT_CLEAR);
	assign stat.fits = fits;
	assign stat.last = (CNT_W'(page_q) + CNT_W'(1)) >= used_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= in_action;
			qw_q <= in_quad_width;
			qh_q <= in_quad_height;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q <= '0;
			used_q <= CNT_W'(1);
			for (int i = 0; i < MAX_PAGES; i++) begin
				cur_x_q[i] <= '0;
				cur_y_q[i] <= '0;
				shelf_q[i] <= '0;
			end
		end else if (cmd.load) begin
			page_q <= '0;
		end else if (cmd.advance) begin
			page_q <= page_q + PAGE_W'(1);
		end else if (cmd.finish) begin
			priority if (stat.is_clear) begin
				for (int i = 0; i < MAX_PAGES; i++) begin
					cur_x_q[i] <= '0;
					cur_y_q[i] <= '0;
					shelf_q[i] <= '0;
				end
			end else if (fits) begin
				cur_x_q[page_q] <= x_try + qw_q;
				cur_y_q[page_q] <= y_try[DIM_W-1:0];
				shelf_q[page_q] <= (sh_try > qh_q) ? sh_try : qh_q;
			end else if (!too_large && !full) begin
				cur_x_q[new_page] <= qw_q;
				cur_y_q[new_page] <= '0;
				shelf_q[new_page] <= qh_q;
				used_q <= used_q + CNT_W'(1);
			end else begin
				// A refused quad leaves every page as it was.
			end
		end
	end

	always_comb begin
		res_status = ST_PLACED;
		res_page_index = '0;
		res_pos_x = '0;
		res_pos_y = '0;
		res_opened_page = 1'b0;
		priority if (stat.is_clear) begin
			res_status = ST_CLEARED;
		end else if (fits) begin
			res_status = ST_PLACED;
			res_page_index = IDX_OUT_W'(page_q);
			res_pos_x = x_try;
			res_pos_y = y_try[DIM_W-1:0];
		end else if (too_large) begin
			res_status = ST_TOO_LARGE;
		end else if (full) begin
			res_status = ST_NO_PAGE;
		end else begin
			res_status = ST_PLACED;
			res_page_index = IDX_OUT_W'(new_page);
			res_opened_page = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_status <= res_status;
			out_page_index <= res_page_index;
			out_pos_x <= res_pos_x;
			out_pos_y <= res_pos_y;
			out_opened_page <= res_opened_page;
		end
	end

endmodule

`default_nettype wire

>>> hdl/shelf_atlas_packer.sv
// Shelf atlas packer: first-fit placement of quads over up to MAX_PAGES pages.
// A word is loaded on acceptance; an insert then walks the pages in use in order, from
// the first, until the quad fits or the last page is reached, and a clear needs no walk.
// The result goes to the output register once it is free; one word is walked at a time;
// the next word is taken once the last result is in the output register.
// Reset is asynchronous: cursors and shelves zero, one page in use, registers to defaults.
`default_nettype none

module shelf_atlas_packer (
	input wire logic clk,
	input wire logic arst_n,
	sap_req_if.sink req,
	sap_rsp_if.source rsp,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [sap_pkg::ADDR_W-1:0] paddr,
	input wire logic [sap_pkg::DATA_W-1:0] pwdata,
	output logic [sap_pkg::DATA_W-1:0] prdata,
	output logic pready
);
	import sap_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	stat_t stat;

	sap_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	sap_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.stat(stat),
		.cmd(cmd)
	);

	sap_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.cmd(cmd),
		.in_action(req.action),
		.in_quad_width(req.quad_width),
		.in_quad_height(req.quad_height),
		.stat(stat),
		.out_status(rsp.status),
		.out_page_index(rsp.page_index),
		.out_pos_x(rsp.pos_x),
		.out_pos_y(rsp.pos_y),
		.out_opened_page(rsp.opened_page)
	);

endmodule

`default_nettype wire

>>> hdl/sap_checker.sv
// Port-level checks of the shelf packer, attached to the top level by bind.
// Depends on sap_pkg and on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sap_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire logic [sap_pkg::STATUS_W-1:0] status,
	input wire logic [sap_pkg::IDX_OUT_W-1:0] page_index,
	input wire logic [sap_pkg::DIM_W-1:0] pos_x,
	input wire logic [sap_pkg::DIM_W-1:0] pos_y,
	input wire logic opened_page
);
	import sap_pkg::*;

	logic at_origin;
	logic fields_zero;

	assign at_origin = (pos_x == '0) && (pos_y == '0);
	assign fields_zero = at_origin && (page_index == '0) && !opened_page;

	`ASSERT_HOLDS(a_rsp_held, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid)
	`ASSERT_HOLDS(a_one_in_flight, clk, arst_n, req_valid && req_ready |=> !req_ready)
	`ASSERT_HOLDS(a_unplaced_zero, clk, arst_n, rsp_valid && status != ST_PLACED |-> fields_zero)
	`ASSERT_HOLDS(a_opened_origin, clk, arst_n, rsp_valid && opened_page |-> at_origin)

endmodule

bind shelf_atlas_packer sap_checker u_sap_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.status(rsp.status),
	.page_index(rsp.page_index),
	.pos_x(rsp.pos_x),
	.pos_y(rsp.pos_y),
	.opened_page(rsp.opened_page)
);

`default_nettype wire
